// ===== rtl/cia_pkg.sv =====
package cia_pkg;

   localparam int WIRE_COUNT_DEF = 256;
   localparam int TICK_COUNT_DEF = 1024;
   localparam int ADDR_MAX_BITS  = 27;
   localparam int CMDQ_DEPTH     = 2;
   localparam int FRAC_BITS      = 20;

   localparam logic [4:0] POOL_MAX = 5'd16;
   localparam logic [7:0] GRAY_MAX = 8'd255;

   localparam logic [1:0] MODE_DEPOSIT = 2'd0;
   localparam logic [1:0] MODE_READ    = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   localparam logic [1:0] REG_GAIN_RECIP  = 2'd0;
   localparam logic [1:0] REG_POOL_FACTOR = 2'd1;
   localparam logic [1:0] REG_WIRE_START  = 2'd2;
   localparam logic [1:0] REG_TICK_START  = 2'd3;

   localparam logic [23:0] GAIN_RECIP_RST  = 24'd65536;
   localparam logic [4:0]  POOL_FACTOR_RST = 5'd1;
   localparam logic [12:0] WIRE_START_RST  = 13'd0;
   localparam logic [13:0] TICK_START_RST  = 14'd0;

   typedef enum logic [1:0] {
      OP_DEPOSIT = 2'd0,
      OP_READ    = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_OUTSIDE = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [ADDR_MAX_BITS-1:0]  addr;
      logic [4:0]                count;
      logic signed [15:0]        charge;
   } cmd_type;

   typedef struct packed {
      logic [23:0] gain_recip;
      logic [4:0]  pool_factor;
      logic [12:0] wire_start;
      logic [13:0] tick_start;
   } cfg_type;

endpackage

// ===== rtl/cia_ram.sv =====
module cia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                           wdata,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/cia_front.sv =====
module cia_front #(
   parameter int WIRE_COUNT = cia_pkg::WIRE_COUNT_DEF,
   parameter int TICK_COUNT = cia_pkg::TICK_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cia_pkg::cfg_type cfg,
   input  logic             clearing,
   input  logic             push,
   output logic             full,
   input  logic [1:0]       req_mode,
   input  logic [12:0]      req_wire_req,
   input  logic [13:0]      req_tick,
   input  logic [15:0]      req_charge,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output cia_pkg::cmd_type cmd
);

   localparam logic [14:0] POOL_LIMIT [17] = '{
      15'(TICK_COUNT),      15'(TICK_COUNT),      15'(TICK_COUNT / 2),
      15'(TICK_COUNT / 3),  15'(TICK_COUNT / 4),  15'(TICK_COUNT / 5),
      15'(TICK_COUNT / 6),  15'(TICK_COUNT / 7),  15'(TICK_COUNT / 8),
      15'(TICK_COUNT / 9),  15'(TICK_COUNT / 10), 15'(TICK_COUNT / 11),
      15'(TICK_COUNT / 12), 15'(TICK_COUNT / 13), 15'(TICK_COUNT / 14),
      15'(TICK_COUNT / 15), 15'(TICK_COUNT / 16)
   };

   logic             stage_valid_ff, stage_valid_in;
   cia_pkg::cmd_type stage_cmd_ff, stage_cmd_in;
   logic             advance, accept;
   logic [4:0]       pf_eff;
   logic [13:0]      wrel, trel;
   logic             dep_out, rd_out;
   logic [12:0]      row;
   logic [14:0]      col, rem;
   logic [18:0]      first;
   logic [4:0]       count;
   logic [27:0]      addr;

   assign advance = stage_valid_ff && cmd_ready;
   assign full    = clearing || (stage_valid_ff && !cmd_ready);
   assign accept  = push && !full;

   always_comb begin
      if (cfg.pool_factor == 5'd0) begin
         pf_eff = 5'd1;
      end else if (cfg.pool_factor > cia_pkg::POOL_MAX) begin
         pf_eff = cia_pkg::POOL_MAX;
      end else begin
         pf_eff = cfg.pool_factor;
      end
   end

   always_comb begin
      wrel    = {1'b0, req_wire_req} - {1'b0, cfg.wire_start};
      trel    = req_tick - cfg.tick_start;
      dep_out = (req_wire_req < cfg.wire_start) || (req_tick < cfg.tick_start)
                || (wrel >= 14'(WIRE_COUNT)) || ({1'b0, trel} >= 15'(TICK_COUNT));
      first   = 19'(req_tick) * 19'(pf_eff);
      if (req_wire_req >= 13'(WIRE_COUNT - 1) + 13'(WIRE_COUNT == 8192 ? 0 : 1)
          && !(WIRE_COUNT == 8192)) begin
         rd_out = 1'b1;
      end else if (pf_eff == 5'd1) begin
         rd_out = {1'b0, req_tick} >= 15'(TICK_COUNT);
      end else begin
         rd_out = {1'b0, req_tick} > POOL_LIMIT[pf_eff];
      end
      rem   = 15'(TICK_COUNT) - first[14:0];
      count = (15'(pf_eff) < rem) ? pf_eff : rem[4:0];
      if (req_mode == cia_pkg::MODE_DEPOSIT) begin
         row = wrel[12:0];
         col = {1'b0, trel};
      end else begin
         row = req_wire_req;
         col = first[14:0];
      end
      addr = 28'(row) * 28'(TICK_COUNT) + 28'(col);
   end

   always_comb begin
      stage_valid_in      = stage_valid_ff && !advance;
      stage_cmd_in        = stage_cmd_ff;
      if (accept) begin
         stage_cmd_in.addr   = addr[cia_pkg::ADDR_MAX_BITS-1:0];
         stage_cmd_in.count  = count;
         stage_cmd_in.charge = $signed(req_charge);
         case (req_mode)
            cia_pkg::MODE_DEPOSIT: begin
               stage_valid_in  = 1'b1;
               stage_cmd_in.op = dep_out ? cia_pkg::OP_OUTSIDE : cia_pkg::OP_DEPOSIT;
            end
            cia_pkg::MODE_READ: begin
               stage_valid_in  = 1'b1;
               stage_cmd_in.op = rd_out ? cia_pkg::OP_OUTSIDE : cia_pkg::OP_READ;
            end
            cia_pkg::MODE_CLEAR: begin
               stage_valid_in  = 1'b1;
               stage_cmd_in.op = cia_pkg::OP_CLEAR;
            end
            default: begin
               stage_valid_in = stage_valid_ff && !advance;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_cmd_ff <= stage_cmd_in;
   end

   assign cmd_valid = stage_valid_ff;
   assign cmd       = stage_cmd_ff;

endmodule

// ===== rtl/cia_cmdq.sv =====
module cia_cmdq #(
   parameter int DEPTH = cia_pkg::CMDQ_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cia_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output cia_pkg::cmd_type out_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cia_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      fill_ff, fill_in;
   logic             do_push, do_pop;

   assign in_ready  = fill_ff != (PW + 1)'(DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         fill_in = (PW + 1)'(fill_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         fill_in = (PW + 1)'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== rtl/cia_back.sv =====
module cia_back #(
   parameter int WIRE_COUNT = cia_pkg::WIRE_COUNT_DEF,
   parameter int TICK_COUNT = cia_pkg::TICK_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [23:0]      gain_recip,
   output logic             clearing,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cia_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             pop,
   output logic [7:0]       rsp_pixel,
   output logic             rsp_outside
);

   localparam int DEPTH = WIRE_COUNT * TICK_COUNT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_CLEAR   = 4'b0001,
      ST_IDLE    = 4'b0010,
      ST_DEPOSIT = 4'b0100,
      ST_READ    = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [4:0]         remain_ff, remain_in;
   logic [7:0]         acc_ff, acc_in;
   logic signed [40:0] prod_ff, prod_in;
   logic               init_ff, init_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         pixel_ff, pixel_in;
   logic               outside_ff, outside_in;

   logic               ram_we;
   logic [AW-1:0]      ram_addr;
   logic [7:0]         ram_wdata, ram_rdata;
   logic               slot_free;
   logic signed [41:0] dep_sum;
   logic [7:0]         dep_pixel;
   logic [8:0]         acc_sum;
   logic [7:0]         acc_sat;

   cia_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign slot_free = !out_valid_ff || pop;

   always_comb begin
      dep_sum = $signed({14'b0, ram_rdata, 20'b0}) + 42'(prod_ff);
      if (dep_sum[41]) begin
         dep_pixel = 8'd0;
      end else if (|dep_sum[40:28]) begin
         dep_pixel = cia_pkg::GRAY_MAX;
      end else begin
         dep_pixel = dep_sum[27:20];
      end
      acc_sum = {1'b0, acc_ff} + {1'b0, ram_rdata};
      acc_sat = acc_sum[8] ? cia_pkg::GRAY_MAX : acc_sum[7:0];
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      init_in      = init_ff;
      out_valid_in = out_valid_ff && !pop;
      pixel_in     = pixel_ff;
      outside_in   = outside_ff;
      ram_we       = 1'b0;
      ram_addr     = addr_ff;
      ram_wdata    = '0;
      cmd_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
               init_in  = 1'b0;
            end else begin
               addr_in = AW'(addr_ff + 1'b1);
            end
         end
         ST_IDLE: begin
            cmd_ready = slot_free;
            ram_addr  = cmd.addr[AW-1:0];
            if (cmd_valid && slot_free) begin
               case (cmd.op)
                  cia_pkg::OP_OUTSIDE: begin
                     out_valid_in = 1'b1;
                     pixel_in     = 8'd0;
                     outside_in   = 1'b1;
                  end
                  cia_pkg::OP_CLEAR: begin
                     state_in = ST_CLEAR;
                     addr_in  = '0;
                  end
                  cia_pkg::OP_DEPOSIT: begin
                     state_in = ST_DEPOSIT;
                     addr_in  = cmd.addr[AW-1:0];
                     prod_in  = 41'($signed(cmd.charge) * $signed({1'b0, gain_recip}));
                  end
                  cia_pkg::OP_READ: begin
                     if (cmd.count == 5'd0) begin
                        out_valid_in = 1'b1;
                        pixel_in     = 8'd0;
                        outside_in   = 1'b0;
                     end else begin
                        state_in  = ST_READ;
                        addr_in   = AW'(cmd.addr[AW-1:0] + 1'b1);
                        remain_in = cmd.count;
                        acc_in    = 8'd0;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DEPOSIT: begin
            ram_we       = 1'b1;
            ram_wdata    = dep_pixel;
            out_valid_in = 1'b1;
            pixel_in     = dep_pixel;
            outside_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_READ: begin
            if (remain_ff == 5'd1) begin
               out_valid_in = 1'b1;
               pixel_in     = acc_sat;
               outside_in   = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               acc_in    = acc_sat;
               addr_in   = AW'(addr_ff + 1'b1);
               remain_in = 5'(remain_ff - 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         init_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         init_ff      <= init_in;
         out_valid_ff <= out_valid_in;
      end
      remain_ff  <= remain_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      pixel_ff   <= pixel_in;
      outside_ff <= outside_in;
   end

   assign clearing    = init_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_pixel   = pixel_ff;
   assign rsp_outside = outside_ff;

endmodule

// ===== rtl/charge_image_accumulate_pool.sv =====
// Charge image accumulator with tick pooling, WIRE_COUNT rows by TICK_COUNT
// columns of 8-bit gray pixels in one single-port RAM.
// Input queue (push/full, req_*): mode 0 deposits a charge sample at an
// absolute wire/tick inside the configured window, mode 1 reads a pooled
// pixel, mode 2 clears the image, mode 3 is dropped without a result.
// Result queue (empty/pop, rsp_*): one transfer per deposit or read; the
// oldest result sits on rsp_* while empty is low and leaves on pop.
// CSR port: gain_recip 0x0, pool_factor 0x4, wire_start 0x8, tick_start 0xC;
// write only while the block is idle.
// Pipeline: one classify stage, a two-entry command queue, then the execute
// unit, which takes one item at a time through the single RAM port: a deposit
// reads the pixel, then writes it back; a read sums the pooled ticks; an
// out-of-window item only posts its result; a clear sweeps the whole image
// one pixel per cycle.
// Reset: registers take their defaults and the whole image is swept to zero,
// WIRE_COUNT*TICK_COUNT pixels (262144 at default size), with full held high.
// When pop stays low, the result register and command queue fill and full
// rises; nothing is lost.
module charge_image_accumulate_pool #(
   parameter int WIRE_COUNT = cia_pkg::WIRE_COUNT_DEF,
   parameter int TICK_COUNT = cia_pkg::TICK_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_mode,
   input  logic [12:0] req_wire_req,
   input  logic [13:0] req_tick,
   input  logic [15:0] req_charge,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_pixel,
   output logic        rsp_outside,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cia_pkg::cfg_type cfg_ff, cfg_in;
   cia_pkg::cmd_type front_cmd, back_cmd;
   logic             front_valid, front_ready, back_valid, back_ready;
   logic             clearing, rsp_valid, csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (paddr[3:2])
            cia_pkg::REG_GAIN_RECIP:  cfg_in.gain_recip  = pwdata[23:0];
            cia_pkg::REG_POOL_FACTOR: cfg_in.pool_factor = pwdata[4:0];
            cia_pkg::REG_WIRE_START:  cfg_in.wire_start  = pwdata[12:0];
            cia_pkg::REG_TICK_START:  cfg_in.tick_start  = pwdata[13:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         cia_pkg::REG_GAIN_RECIP:  prdata = {8'd0, cfg_ff.gain_recip};
         cia_pkg::REG_POOL_FACTOR: prdata = {27'd0, cfg_ff.pool_factor};
         cia_pkg::REG_WIRE_START:  prdata = {19'd0, cfg_ff.wire_start};
         cia_pkg::REG_TICK_START:  prdata = {18'd0, cfg_ff.tick_start};
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_recip  <= cia_pkg::GAIN_RECIP_RST;
         cfg_ff.pool_factor <= cia_pkg::POOL_FACTOR_RST;
         cfg_ff.wire_start  <= cia_pkg::WIRE_START_RST;
         cfg_ff.tick_start  <= cia_pkg::TICK_START_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cia_front #(
      .WIRE_COUNT(WIRE_COUNT),
      .TICK_COUNT(TICK_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .clearing    (clearing),
      .push        (push),
      .full        (full),
      .req_mode    (req_mode),
      .req_wire_req(req_wire_req),
      .req_tick    (req_tick),
      .req_charge  (req_charge),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready),
      .cmd         (front_cmd)
   );

   cia_cmdq #(
      .DEPTH(cia_pkg::CMDQ_DEPTH)
   ) u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (front_valid),
      .in_ready (front_ready),
      .in_cmd   (front_cmd),
      .out_valid(back_valid),
      .out_ready(back_ready),
      .out_cmd  (back_cmd)
   );

   cia_back #(
      .WIRE_COUNT(WIRE_COUNT),
      .TICK_COUNT(TICK_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .gain_recip (cfg_ff.gain_recip),
      .clearing   (clearing),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_valid  (rsp_valid),
      .pop        (pop),
      .rsp_pixel  (rsp_pixel),
      .rsp_outside(rsp_outside)
   );

   assign empty = !rsp_valid;

endmodule

// ===== test/charge_image_checker.sv =====
`timescale 1ns / 1ps
module charge_image_checker #(
   parameter int WIRES = cia_pkg::WIRE_COUNT_DEF,
   parameter int TICKS = cia_pkg::TICK_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [1:0]  req_mode,
   input  logic [12:0] req_wire_req,
   input  logic [13:0] req_tick,
   input  logic [15:0] req_charge,
   input  logic        empty,
   input  logic        pop,
   input  logic [7:0]  rsp_pixel,
   input  logic        rsp_outside,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          pending,
   output int          checked
);
   import cia_pkg::*;

   typedef struct packed {
      logic [7:0] pixel;
      logic       outside;
   } gray_result_type;

   gray_result_type gray_expected_q[$];
   logic [7:0]   image_copy[WIRES*TICKS];
   logic [23:0]  gain;
   logic [4:0]   pool;
   logic [12:0]  wire_base;
   logic [13:0]  tick_base;
   bit           image_wiped = 1'b0;

   function automatic void wipe_image();
      foreach (image_copy[i]) image_copy[i] = 8'd0;
   endfunction

   task automatic predict_gray(input logic [1:0] mode, input logic [12:0] w,
                               input logic [13:0] t, input logic [15:0] c);
      gray_result_type   r;
      int unsigned       wi, ti, pf, first, idx, sum;
      logic signed [15:0] q;
      longint            acc;
      r = '0;
      wi = w;
      ti = t;
      q = c;
      if (mode == MODE_CLEAR) begin
         wipe_image();
      end else if (mode == MODE_DEPOSIT) begin
         if (wi < wire_base || ti < tick_base || wi - wire_base >= WIRES ||
             ti - tick_base >= TICKS) begin
            r.outside = 1'b1;
         end else begin
            idx = (wi - wire_base) * TICKS + (ti - tick_base);
            acc = (longint'(image_copy[idx]) <<< FRAC_BITS) + longint'(q) * longint'(gain);
            if (acc < 0) r.pixel = 8'd0;
            else if ((acc >>> FRAC_BITS) > longint'(GRAY_MAX)) r.pixel = GRAY_MAX;
            else r.pixel = 8'(acc >>> FRAC_BITS);
            image_copy[idx] = r.pixel;
         end
         gray_expected_q = {gray_expected_q, r};
      end else if (mode == MODE_READ) begin
         pf = (pool == 5'd0) ? 1 : (pool > POOL_MAX) ? POOL_MAX : pool;
         if (wi >= WIRES) begin
            r.outside = 1'b1;
         end else if (pf == 1) begin
            if (ti >= TICKS) r.outside = 1'b1;
            else r.pixel = image_copy[wi * TICKS + ti];
         end else if (ti > TICKS / pf) begin
            r.outside = 1'b1;
         end else begin
            sum = 0;
            first = ti * pf;
            for (int k = 0; k < pf && first + k < TICKS; k++) begin
               sum += image_copy[wi * TICKS + first + k];
               if (sum > GRAY_MAX) sum = GRAY_MAX;
            end
            r.pixel = 8'(sum);
         end
         gray_expected_q = {gray_expected_q, r};
      end
   endtask

   always @(posedge clock) begin
      gray_result_type want;
      if (reset) begin
         gain = GAIN_RECIP_RST;
         pool = POOL_FACTOR_RST;
         wire_base = WIRE_START_RST;
         tick_base = TICK_START_RST;
         fail_count = 0;
         checked = 0;
         gray_expected_q.delete();
         if (!image_wiped) begin
            wipe_image();
            image_wiped = 1'b1;
         end
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_GAIN_RECIP:  gain = pwdata[23:0];
               REG_POOL_FACTOR: pool = pwdata[4:0];
               REG_WIRE_START:  wire_base = pwdata[12:0];
               REG_TICK_START:  tick_base = pwdata[13:0];
               default: ;
            endcase
         end
         if (pop && !empty) begin
            if (gray_expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected transfer, expected none, got pixel %0d outside %0b",
                        $time, rsp_pixel, rsp_outside);
            end else begin
               want = gray_expected_q.pop_front();
               checked++;
               if (rsp_pixel !== want.pixel) begin
                  fail_count++;
                  $display("%0t: pixel mismatch, expected %0d, got %0d",
                           $time, want.pixel, rsp_pixel);
               end
               if (rsp_outside !== want.outside) begin
                  fail_count++;
                  $display("%0t: outside mismatch, expected %0b, got %0b",
                           $time, want.outside, rsp_outside);
               end
            end
         end
         if (push && !full) predict_gray(req_mode, req_wire_req, req_tick, req_charge);
      end
      pending <= gray_expected_q.size();
   end

endmodule

// ===== test/tb_charge_image_accumulate_pool.sv =====
`timescale 1ns / 1ps
module tb_charge_image_accumulate_pool;
   import cia_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int WIRES         = WIRE_COUNT_DEF;
   localparam int TICKS         = TICK_COUNT_DEF;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 92;
   localparam int HOLD_CYCLES   = 400;

   logic        clock = 1'b0;
   logic        reset, push, full, empty, pop;
   logic [1:0]  req_mode;
   logic [12:0] req_wire_req;
   logic [13:0] req_tick;
   logic [15:0] req_charge;
   logic [7:0]  rsp_pixel;
   logic        rsp_outside;
   logic        psel, penable, pwrite, pready;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        hold_go, steady;
   int          fail_count, pending, checked;
   int          n_deposit, n_read, n_clear, n_ignored, n_settings;

   always #5 clock = ~clock;

   charge_image_accumulate_pool u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_mode(req_mode), .req_wire_req(req_wire_req), .req_tick(req_tick),
      .req_charge(req_charge), .empty(empty), .pop(pop),
      .rsp_pixel(rsp_pixel), .rsp_outside(rsp_outside),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   charge_image_checker u_checker (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_mode(req_mode), .req_wire_req(req_wire_req), .req_tick(req_tick),
      .req_charge(req_charge), .empty(empty), .pop(pop),
      .rsp_pixel(rsp_pixel), .rsp_outside(rsp_outside),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [23:0] gain, input logic [4:0] pool,
                                 input logic [12:0] ws, input logic [13:0] ts);
      write_reg(REG_GAIN_RECIP, 32'(gain));
      write_reg(REG_POOL_FACTOR, 32'(pool));
      write_reg(REG_WIRE_START, 32'(ws));
      write_reg(REG_TICK_START, 32'(ts));
      n_settings++;
   endtask

   task automatic offer(input logic [1:0] mode, input logic [12:0] w,
                        input logic [13:0] t, input logic [15:0] c);
      int gap, pick;
      req_mode <= mode;
      req_wire_req <= w;
      req_tick <= t;
      req_charge <= c;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      case (mode)
         MODE_DEPOSIT: n_deposit++;
         MODE_READ:    n_read++;
         MODE_CLEAR:   n_clear++;
         default:      n_ignored++;
      endcase
      pick = $urandom_range(0, 99);
      if (steady || pick < 60) gap = 0;
      else if (pick < 93) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int phase);
      int          pick, row_base, col_base, pf;
      logic [1:0]  mode;
      logic [12:0] w;
      logic [13:0] t;
      logic [15:0] c;
      logic [23:0] gain;
      logic [4:0]  pool;
      logic [12:0] ws;
      logic [13:0] ts;
      pick = $urandom_range(0, 99);
      if (pick < 25) gain = GAIN_RECIP_RST;
      else if (pick < 40) gain = 24'hFFFFFF;
      else if (pick < 50) gain = 24'd0;
      else gain = 24'($urandom_range(4096, 262143));
      pick = $urandom_range(0, 99);
      if (pick < 15) pool = 5'd1;
      else if (pick < 25) pool = 5'd0;
      else if (pick < 35) pool = 5'($urandom_range(17, 31));
      else if (pick < 45) pool = POOL_MAX;
      else pool = 5'($urandom_range(2, 15));
      pick = $urandom_range(0, 99);
      if (pick < 20) ws = 13'd0;
      else if (pick < 30) ws = 13'(8191 - $urandom_range(0, 300));
      else ws = 13'($urandom_range(0, 8191));
      pick = $urandom_range(0, 99);
      if (pick < 20) ts = 14'd0;
      else if (pick < 30) ts = 14'(16383 - $urandom_range(0, 1100));
      else ts = 14'($urandom_range(0, 16383));
      apply_settings(gain, pool, ws, ts);
      steady <= (phase % 3 == 1);
      pf = (pool == 5'd0) ? 1 : (pool > POOL_MAX) ? POOL_MAX : pool;
      row_base = $urandom_range(0, WIRES - 8);
      col_base = $urandom_range(0, TICKS - 64);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         if (phase == 2 && k == 10) hold_go <= 1'b1;
         if (phase == 5 && k == 50) drain();
         if (phase == 4 && k == 45) offer(MODE_CLEAR, 13'd0, 14'd0, 16'd0);
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 9) < 7) c = 16'($urandom_range(0, 1600) - 800);
         else c = 16'($urandom());
         if (k == PHASE_ITEMS - 1) pick = 99;
         if (pick < 10) begin
            if ($urandom_range(0, 3) == 0) mode = MODE_UNUSED;
            else mode = ($urandom_range(0, 1) != 0) ? MODE_READ : MODE_DEPOSIT;
            offer(mode, 13'($urandom()), 14'($urandom()), 16'($urandom()));
         end else if (pick < 58) begin
            w = 13'(ws + row_base + $urandom_range(0, 7));
            t = 14'(ts + col_base + $urandom_range(0, 63));
            offer(MODE_DEPOSIT, w, t, c);
         end else begin
            w = 13'(row_base + $urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) t = 14'(TICKS / pf - (pf == 1) + $urandom_range(0, 1));
            else t = 14'((col_base + $urandom_range(0, 63)) / pf);
            offer(MODE_READ, w, t, c);
         end
      end
      drain();
   endtask

   // result side: random stalls, one long hold to back the block up
   initial begin
      int stall, pick;
      bit held;
      held = 1'b0;
      pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (steady || pick < 55) stall = 0;
         else if (pick < 94) stall = $urandom_range(1, 3);
         else stall = $urandom_range(15, 50);
         if (hold_go && !held) begin
            held = 1'b1;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
      end
   end

   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      req_mode <= MODE_DEPOSIT;
      req_wire_req <= '0;
      req_tick <= '0;
      req_charge <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      hold_go <= 1'b0;
      steady <= 1'b0;
      n_deposit = 0;
      n_read = 0;
      n_clear = 0;
      n_ignored = 0;
      n_settings = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset sweep of the image
      while (full) @(posedge clock);

      apply_settings(GAIN_RECIP_RST, POOL_FACTOR_RST, WIRE_START_RST, TICK_START_RST);
      offer(MODE_DEPOSIT, 13'd0, 14'd0, 16'h7FFF);
      offer(MODE_DEPOSIT, 13'd0, 14'd0, 16'h8000);
      offer(MODE_DEPOSIT, 13'd0, 14'd1, 16'd160);
      offer(MODE_DEPOSIT, 13'd0, 14'd1, 16'd7);
      offer(MODE_DEPOSIT, 13'd255, 14'd1023, 16'd100);
      offer(MODE_DEPOSIT, 13'd256, 14'd0, 16'd5);
      offer(MODE_DEPOSIT, 13'd8191, 14'd16383, 16'hFFFF);
      offer(MODE_READ, 13'd0, 14'd1, 16'd0);
      offer(MODE_READ, 13'd255, 14'd1023, 16'hFFFF);
      offer(MODE_READ, 13'd256, 14'd0, 16'd0);
      offer(MODE_READ, 13'd0, 14'd1024, 16'd0);
      offer(MODE_READ, 13'd8191, 14'd16383, 16'd0);
      offer(MODE_UNUSED, 13'd8191, 14'd16383, 16'hFFFF);
      offer(MODE_CLEAR, 13'd0, 14'd0, 16'd0);
      offer(MODE_READ, 13'd255, 14'd1023, 16'd0);
      drain();

      apply_settings(24'hFFFFFF, POOL_MAX, 13'd8191, 14'd16383);
      offer(MODE_DEPOSIT, 13'd8191, 14'd16383, 16'd1);
      offer(MODE_DEPOSIT, 13'd8190, 14'd16383, 16'd1);
      offer(MODE_DEPOSIT, 13'd8191, 14'd16382, 16'd1);
      offer(MODE_READ, 13'd0, 14'd0, 16'd0);
      offer(MODE_READ, 13'd0, 14'd64, 16'd0);
      offer(MODE_READ, 13'd0, 14'd65, 16'd0);
      drain();

      // zero gain leaves the pixel alone; pool factor zero reads plain
      apply_settings(24'd0, 5'd0, 13'd0, 14'd0);
      offer(MODE_DEPOSIT, 13'd0, 14'd0, 16'h7FFF);
      offer(MODE_READ, 13'd0, 14'd0, 16'd0);
      drain();

      // pool factor above the maximum saturates
      apply_settings(GAIN_RECIP_RST, 5'd31, 13'd0, 14'd0);
      offer(MODE_READ, 13'd0, 14'd0, 16'd0);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);

      repeat (40) @(posedge clock);
      $display("covered %0d deposits, %0d reads, %0d clears, %0d ignored items",
               n_deposit, n_read, n_clear, n_ignored);
      $display("%0d results checked over %0d register settings with a long result stall",
               checked, n_settings);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
